// ----- sv/mcb_pkg.sv -----
// Shared types and constants of the maze carving backtracker.
package mcb_pkg;

    localparam int CELL_W      = 12;
    localparam int DIR_W       = 2;
    localparam int RAND_W      = 8;
    localparam int SIZE_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int DIV_STEPS   = 12;
    localparam int DIV_CNT_W   = 4;
    localparam int NUM_DIRS    = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 2'd1;

    // Carving directions
    localparam logic [DIR_W-1:0] DIR_TOP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BOTTOM = 2'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT   = 2'd3;

    typedef struct packed {
        logic              restart;
        logic [RAND_W-1:0] random_value;
    } item_t;

    typedef struct packed {
        logic              carved;
        logic [CELL_W-1:0] from_cell;
        logic [DIR_W-1:0]  direction;
        logic [CELL_W-1:0] current_cell;
        logic              done_res;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             clr_en;
        logic             restart_load;
        logic             div_load;
        logic             div_step;
        logic             rd_en;
        logic [DIR_W-1:0] rd_dir;
        logic             cap_en;
        logic [DIR_W-1:0] cap_dir;
        logic             carve;
        logic             pop_rd;
        logic             pop_load;
        logic             finish;
        logic             report;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic item_restart;
        logic finished;
        logic clr_last;
        logic div_last;
        logic can_carve;
        logic stack_empty;
    } ctrl_stat_t;

endpackage

// ----- sv/maze_carve_backtracker_top.sv -----
// Top level of the maze carving backtracker.
//
//  channel   ports                                  handshake
//  --------  -------------------------------------  -------------------------------
//  item in   start, item, busy                      taken when start high, busy low
//  result    result_valid, result                   one-cycle strobe, never stalled
//  config    cfg_valid, cfg_ready, cfg_index, data  written when valid and ready
//
// In a step, a bit-serial divide splits the current cell into column and row,
// then come four visited-map reads on its single read port and a decide state;
// a step that pops then passes through a pop state before the strobe.
// A step after the maze is done goes straight to its report. Reset and restart
// sweep the visited map, one entry a cycle; busy stays high meanwhile.
// The next item may be taken in the cycle its predecessor's result is strobed.
module maze_carve_backtracker_top
    import mcb_pkg::*;
#(
    parameter int MAX_CELLS = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  item_t                 item,
    output logic                  busy,
    output logic                  result_valid,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  ctl_cmd;
    ctrl_stat_t ctl_stat;

    // Sizes are taken at any time
    assign cfg_ready = 1'b1;

    mcb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (ctl_stat),
        .cmd   (ctl_cmd)
    );

    mcb_dpath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (ctl_cmd),
        .stat         (ctl_stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- sv/mcb_ctrl.sv -----
// Step sequencer of the maze carving backtracker.
module mcb_ctrl
    import mcb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PROBE,
        S_DECIDE,
        S_POP,
        S_REPORT
    } state_t;

    localparam logic [2:0] PROBE_LAST = 3'd4;

    state_t     state_reg, state_next;
    logic [2:0] probe_cnt_reg, probe_cnt_next;
    logic       pending_reg, pending_next;
    logic       busy_reg;

    // Decode commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        probe_cnt_next = probe_cnt_reg;
        pending_next   = pending_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.restart_load = 1'b1;
                    pending_next     = 1'b0;
                    state_next       = pending_reg ? S_REPORT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (stat.item_restart)
                    begin
                        pending_next = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    else if (stat.finished)
                    begin
                        state_next = S_REPORT;
                    end
                    else
                    begin
                        cmd.div_load = 1'b1;
                        state_next   = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    probe_cnt_next = 3'd0;
                    state_next     = S_PROBE;
                end
            end
            S_PROBE:
            begin
                // Issue one neighbor read a cycle, capture the one before
                cmd.rd_en   = (probe_cnt_reg != PROBE_LAST);
                cmd.rd_dir  = probe_cnt_reg[DIR_W-1:0];
                cmd.cap_en  = (probe_cnt_reg != 3'd0);
                cmd.cap_dir = probe_cnt_reg[DIR_W-1:0] - 2'd1;
                if (probe_cnt_reg == PROBE_LAST)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    probe_cnt_next = probe_cnt_reg + 3'd1;
                end
            end
            S_DECIDE:
            begin
                if (stat.can_carve)
                begin
                    cmd.carve  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!stat.stack_empty)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                cmd.pop_load = 1'b1;
                state_next   = S_IDLE;
            end
            S_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            probe_cnt_reg <= 3'd0;
            pending_reg   <= 1'b0;
            busy_reg      <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            probe_cnt_reg <= probe_cnt_next;
            pending_reg   <= pending_next;
            busy_reg      <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

// ----- sv/mcb_dpath.sv -----
// Datapath of the maze carving backtracker: sizes, divider, visited map, stack.
module mcb_dpath
    import mcb_pkg::*;
#(
    parameter int MAX_CELLS = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  item_t                 item,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ctrl_cmd_t             cmd,
    output ctrl_stat_t            stat,
    output logic                  result_valid,
    output result_t               result
);

    localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int SD_W   = $clog2(MAX_CELLS + 1);
    localparam int NB_W   = CELL_W + 1;
    localparam int EXT_W  = (ADDR_W > NB_W) ? ADDR_W : NB_W;

    // Size registers and clamped sizes
    logic [SIZE_W-1:0] cols_reg, rows_reg;
    logic [SIZE_W-1:0] cols_c, rows_c;

    // Walk state
    logic [CELL_W-1:0] cur_reg;
    logic [SD_W-1:0]   depth_reg;
    logic [SD_W-1:0]   depth_dec;
    logic              finished_reg;
    logic [RAND_W-1:0] rand_reg;

    // Divider: quotient is the row, remainder the column
    logic [CELL_W-1:0]    div_num_reg, div_num_next;
    logic [SIZE_W-1:0]    div_rem_reg, div_rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [SIZE_W-1:0]    rem_sh;
    logic                 rem_ge;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              clr_last;

    // Neighbors
    logic [NUM_DIRS-1:0] nb_in;
    logic [NUM_DIRS-1:0] nb_ok;
    logic [NB_W-1:0]     nb_idx [NUM_DIRS];
    logic [EXT_W-1:0]    nb_ext [NUM_DIRS];
    logic [ADDR_W-1:0]   nb_addr [NUM_DIRS];
    logic [NB_W-1:0]     cur_w, cols_w;
    logic                row_in;

    logic [NUM_DIRS-1:0] open_reg;
    logic [2:0]          open_count;
    logic [DIR_W-1:0]    pick_idx;
    logic [DIR_W-1:0]    pick_dir;
    logic                can_carve;
    logic                stack_empty;

    // Memories
    logic              vis_mem [MAX_CELLS];
    logic [CELL_W-1:0] stack_mem [MAX_CELLS];
    logic              vis_we, vis_wdata;
    logic [ADDR_W-1:0] vis_waddr;
    logic              vis_rdata_reg;
    logic [CELL_W-1:0] stack_rdata_reg;

    result_t result_next;
    logic    emit;
    logic    result_valid_reg;
    result_t result_reg;

    // Reduce an 8-bit value modulo three by summing base-4 digits
    function automatic logic [1:0] mod3_8(input logic [RAND_W-1:0] v);
        logic [3:0] s;
        logic [2:0] t;
        logic [1:0] m;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        case (t) inside
            3'd3, 3'd4, 3'd5: m = 2'(t - 3'd3);
            3'd6:             m = 2'd0;
            default:          m = t[1:0];
        endcase
        return m;
    endfunction

    // Clamp sizes to one through sixty-four
    always_comb
    begin
        cols_c = (cols_reg == '0) ? 7'd1 : ((cols_reg > 7'd64) ? 7'd64 : cols_reg);
        rows_c = (rows_reg == '0) ? 7'd1 : ((rows_reg > 7'd64) ? 7'd64 : rows_reg);
    end

    // One restoring divide step
    always_comb
    begin
        rem_sh       = {div_rem_reg[SIZE_W-2:0], div_num_reg[CELL_W-1]};
        rem_ge       = (rem_sh >= cols_c);
        div_rem_next = rem_ge ? (rem_sh - cols_c) : rem_sh;
        div_num_next = {div_num_reg[CELL_W-2:0], rem_ge};
    end

    // Locate the four neighbors of the current cell
    always_comb
    begin
        cur_w  = {1'b0, cur_reg};
        cols_w = NB_W'(cols_c);
        row_in = (div_num_reg < CELL_W'(rows_c));
        nb_in[DIR_TOP]    = (div_num_reg != '0) && (div_num_reg <= CELL_W'(rows_c));
        nb_in[DIR_RIGHT]  = ((div_rem_reg + 7'd1) < cols_c) && row_in;
        nb_in[DIR_BOTTOM] = (({1'b0, div_num_reg} + 13'd1) < NB_W'(rows_c));
        nb_in[DIR_LEFT]   = (div_rem_reg != '0) && row_in;
        nb_idx[DIR_TOP]    = cur_w - cols_w;
        nb_idx[DIR_RIGHT]  = cur_w + 13'd1;
        nb_idx[DIR_BOTTOM] = cur_w + cols_w;
        nb_idx[DIR_LEFT]   = cur_w - 13'd1;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            nb_ok[d]   = nb_in[d] && ({19'd0, nb_idx[d]} < 32'(MAX_CELLS));
            nb_ext[d]  = EXT_W'(nb_idx[d]);
            nb_addr[d] = nb_ext[d][ADDR_W-1:0];
        end
    end

    // Choose among the open neighbors
    always_comb
    begin
        logic [2:0] seen;
        logic       found;
        open_count = 3'($countones(open_reg));
        case (open_count)
            3'd1:    pick_idx = 2'd0;
            3'd2:    pick_idx = {1'b0, rand_reg[0]};
            3'd3:    pick_idx = mod3_8(rand_reg);
            3'd4:    pick_idx = rand_reg[1:0];
            default: pick_idx = 2'd0;
        endcase
        seen     = 3'd0;
        found    = 1'b0;
        pick_dir = DIR_TOP;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            if (open_reg[d] && !found)
            begin
                if (seen == {1'b0, pick_idx})
                begin
                    pick_dir = 2'(d);
                    found    = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
    end

    assign depth_dec   = depth_reg - SD_W'(1);
    assign stack_empty = (depth_reg == '0);
    assign can_carve   = (open_count != 3'd0) && (depth_reg < SD_W'(MAX_CELLS));
    assign clr_last    = (clr_cnt_reg == ADDR_W'(MAX_CELLS - 1));

    assign stat.item_restart = item.restart;
    assign stat.finished     = finished_reg;
    assign stat.clr_last     = clr_last;
    assign stat.div_last     = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign stat.can_carve    = can_carve;
    assign stat.stack_empty  = stack_empty;

    // Visited map port selection
    always_comb
    begin
        vis_we    = cmd.clr_en | cmd.carve;
        vis_waddr = cmd.clr_en ? clr_cnt_reg : nb_addr[pick_dir];
        vis_wdata = cmd.clr_en ? (clr_cnt_reg == '0) : 1'b1;
    end

    // Visited map
    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        if (cmd.rd_en)
        begin
            vis_rdata_reg <= vis_mem[nb_addr[cmd.rd_dir]];
        end
    end

    // Return stack
    always_ff @(posedge clk)
    begin
        if (cmd.carve)
        begin
            stack_mem[depth_reg[ADDR_W-1:0]] <= cur_reg;
        end
        if (cmd.pop_rd)
        begin
            stack_rdata_reg <= stack_mem[depth_dec[ADDR_W-1:0]];
        end
    end

    // Build the result of this step
    always_comb
    begin
        result_next = '0;
        emit        = cmd.carve | cmd.pop_load | cmd.finish | cmd.report;
        if (cmd.carve)
        begin
            result_next.carved       = 1'b1;
            result_next.from_cell    = cur_reg;
            result_next.direction    = pick_dir;
            result_next.current_cell = nb_idx[pick_dir][CELL_W-1:0];
            result_next.done_res     = finished_reg;
        end
        else if (cmd.pop_load)
        begin
            result_next.current_cell = stack_rdata_reg;
            result_next.done_res     = stack_empty;
        end
        else if (cmd.finish)
        begin
            result_next.current_cell = cur_reg;
            result_next.done_res     = 1'b1;
        end
        else
        begin
            result_next.current_cell = cur_reg;
            result_next.done_res     = finished_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg         <= 7'd16;
            rows_reg         <= 7'd16;
            cur_reg          <= '0;
            depth_reg        <= '0;
            finished_reg     <= 1'b0;
            div_cnt_reg      <= '0;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // Take size writes
            if (cfg_valid && (cfg_index == REG_NUM_COLUMNS))
            begin
                cols_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == REG_NUM_ROWS))
            begin
                rows_reg <= cfg_data;
            end

            // Advance the clearing sweep
            if (cmd.clr_en)
            begin
                clr_cnt_reg <= clr_last ? '0 : (clr_cnt_reg + ADDR_W'(1));
            end

            if (cmd.div_load)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end

            // Move, push and pop
            if (cmd.restart_load)
            begin
                cur_reg      <= '0;
                depth_reg    <= '0;
                finished_reg <= 1'b0;
            end
            else if (cmd.carve)
            begin
                cur_reg   <= nb_idx[pick_dir][CELL_W-1:0];
                depth_reg <= depth_reg + SD_W'(1);
            end
            else if (cmd.pop_rd)
            begin
                depth_reg <= depth_dec;
            end
            else if (cmd.pop_load)
            begin
                cur_reg <= stack_rdata_reg;
                if (stack_empty)
                begin
                    finished_reg <= 1'b1;
                end
            end
            else if (cmd.finish)
            begin
                finished_reg <= 1'b1;
            end

            result_valid_reg <= emit;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rand_reg    <= item.random_value;
            div_num_reg <= cur_reg;
            div_rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_num_reg <= div_num_next;
            div_rem_reg <= div_rem_next;
        end
        if (cmd.cap_en)
        begin
            open_reg[cmd.cap_dir] <= nb_ok[cmd.cap_dir] & ~vis_rdata_reg;
        end
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe longer than one cycle");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= SD_W'(MAX_CELLS))
        else $error("stack depth beyond capacity");

    a_carve_target: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.carve |=> ({20'd0, cur_reg} < 32'(MAX_CELLS)))
        else $error("carved into a cell outside the map");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_rd |-> !stack_empty)
        else $error("pop from an empty stack");

    a_finished_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (finished_reg && !cmd.restart_load) |=> finished_reg)
        else $error("finished dropped without restart");

endmodule

// ----- sim/tb_maze_carve_backtracker_top.sv -----
// Self-checking testbench of the maze carving backtracker: directed and random steps.
`timescale 1ns / 100ps

import mcb_pkg::*;

// Tracks the carving walk, predicts every result and checks the block against it
class maze_scoreboard #(int GRID_CELLS = 4096);

    localparam int MAX_SIDE = 64;

    bit                visited[GRID_CELLS];
    bit [CELL_W-1:0]   trail[GRID_CELLS];
    int unsigned       trail_depth;
    bit [CELL_W-1:0]   position;
    bit                maze_done;
    bit [SIZE_W-1:0]   columns_reg;
    bit [SIZE_W-1:0]   rows_reg;
    result_t           expected_moves[$];
    int unsigned       mismatches;

    function new();
        columns_reg = SIZE_W'(16);
        rows_reg    = SIZE_W'(16);
        mismatches  = 0;
        clear_maze();
    endfunction

    // Drop the walk and start over at cell 0
    function void clear_maze();
        foreach (visited[i])
        begin
            visited[i] = 1'b0;
        end
        visited[0]  = 1'b1;
        trail_depth = 0;
        position    = '0;
        maze_done   = 1'b0;
    endfunction

    // Sizes of 0 act as 1, sizes above the maximum side act as the maximum
    function int unsigned clamp_dim(logic [SIZE_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return int'(v);
    endfunction

    function void write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_NUM_COLUMNS: columns_reg = val;
            REG_NUM_ROWS:    rows_reg    = val;
            default:         ;
        endcase
    endfunction

    // Index of an in-grid unvisited cell, or -1
    function int cell_if_open(int col, int row, int cols, int rows);
        int idx;
        if (col < 0 || row < 0 || col >= cols || row >= rows)
            return -1;
        idx = col + row * cols;
        if (idx >= GRID_CELLS)
            return -1;
        if (visited[idx])
            return -1;
        return idx;
    endfunction

    // Advance the walk by one item and return the move it produces
    function result_t carve_step(item_t it);
        result_t          r;
        int               cols;
        int               rows;
        int               col;
        int               row;
        int               idx;
        int               count;
        int               pick;
        int               cand[NUM_DIRS];
        logic [DIR_W-1:0] cdir[NUM_DIRS];
        logic [DIR_W-1:0] d;
        r = '0;
        if (it.restart)
        begin
            clear_maze();
        end
        else if (!maze_done)
        begin
            cols  = clamp_dim(columns_reg);
            rows  = clamp_dim(rows_reg);
            col   = int'(position) % cols;
            row   = int'(position) / cols;
            count = 0;
            // Gather open neighbours in top, right, bottom, left order
            for (int k = 0; k < NUM_DIRS; k++)
            begin
                d = DIR_W'(k);
                case (d)
                    DIR_TOP:    idx = cell_if_open(col, row - 1, cols, rows);
                    DIR_RIGHT:  idx = cell_if_open(col + 1, row, cols, rows);
                    DIR_BOTTOM: idx = cell_if_open(col, row + 1, cols, rows);
                    default:    idx = cell_if_open(col - 1, row, cols, rows);
                endcase
                if (idx >= 0)
                begin
                    cand[count] = idx;
                    cdir[count] = d;
                    count++;
                end
            end
            if (count > 0 && trail_depth < GRID_CELLS)
            begin
                pick               = int'(it.random_value) % count;
                r.carved           = 1'b1;
                r.from_cell        = position;
                r.direction        = cdir[pick];
                trail[trail_depth] = position;
                trail_depth++;
                visited[cand[pick]] = 1'b1;
                position           = CELL_W'(cand[pick]);
            end
            else if (trail_depth > 0)
            begin
                // Backtrack; emptying the stack completes the maze
                trail_depth--;
                position = trail[trail_depth];
                if (trail_depth == 0)
                    maze_done = 1'b1;
            end
            else
            begin
                // Dead end with nothing to pop: finish at once
                maze_done = 1'b1;
            end
        end
        r.current_cell = position;
        r.done_res     = maze_done;
        return r;
    endfunction

    function void note_step(item_t it);
        result_t move;
        move           = carve_step(it);
        expected_moves = {expected_moves, move};
    endfunction

    function int pending();
        return expected_moves.size();
    endfunction

    function void compare_field(string field, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (expected_moves.size() == 0)
        begin
            $error("result with no item outstanding: %h", got);
            mismatches++;
            return;
        end
        want = expected_moves.pop_front();
        compare_field("carved", CELL_W'(want.carved), CELL_W'(got.carved));
        compare_field("from_cell", want.from_cell, got.from_cell);
        compare_field("direction", CELL_W'(want.direction), CELL_W'(got.direction));
        compare_field("current_cell", want.current_cell, got.current_cell);
        compare_field("done_res", CELL_W'(want.done_res), CELL_W'(got.done_res));
    endfunction

endclass

module tb_maze_carve_backtracker_top;

    localparam int GRID_CELLS   = 4096;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int DRAIN_CYCLES = 40;

    // Indexes past the register list
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    item_t                 item = '0;
    logic                  busy;
    logic                  result_valid;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    maze_scoreboard #(GRID_CELLS) sb;
    int unsigned                  burst_left = 0;
    int unsigned                  cycle_count = 0;

    maze_carve_backtracker_top #(
        .MAX_CELLS(GRID_CELLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .item(item),
        .busy(busy),
        .result_valid(result_valid),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Watch all three channels at each rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_result(result);
            if (start && !busy)
                sb.note_step(item);
            if (cfg_valid && cfg_ready)
                sb.write_size(cfg_index, cfg_data);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic item_t step_item(logic restart, logic [RAND_W-1:0] rv);
        item_t it;
        it.restart      = restart;
        it.random_value = rv;
        return it;
    endfunction

    // Mostly small sides, now and then the extremes
    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 19))
            0:       return SIZE_W'(0);
            1:       return SIZE_W'(127);
            2:       return SIZE_W'(64);
            3:       return SIZE_W'($urandom_range(65, 127));
            4, 5:    return SIZE_W'($urandom_range(7, 16));
            default: return SIZE_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Offer one item, idling between bursts; return at the edge that takes it
    task automatic send_item(input item_t it);
        cfg_valid <= 1'b0;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
    endtask

    // Write one register once the block has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        start     <= 1'b0;
        cfg_valid <= 1'b0;
        // Let an item taken at this edge show up as busy and pending
        @(posedge clk);
        while (sb.pending() != 0 || busy) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    initial
    begin
        int unsigned       steps_sent;
        int unsigned       cells;
        int unsigned       walk_len;
        int unsigned       noise;
        logic [SIZE_W-1:0] cols_now;
        logic [SIZE_W-1:0] rows_now;

        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Default 16x16 grid from cell 0
        send_item(step_item(1'b0, 8'h00));
        send_item(step_item(1'b0, 8'hFF));
        send_item(step_item(1'b0, 8'hAA));
        send_item(step_item(1'b0, 8'h55));

        // Narrow the grid mid-walk
        write_reg(REG_NUM_COLUMNS, 7'd3);
        send_item(step_item(1'b0, 8'h01));
        send_item(step_item(1'b0, 8'h02));

        // Ignored index, then a single-cell grid: done at once, then idle steps
        write_reg(REG_SPARE_HI, 7'h7F);
        write_reg(REG_NUM_COLUMNS, 7'd1);
        write_reg(REG_NUM_ROWS, 7'd1);
        send_item(step_item(1'b1, 8'hFF));
        send_item(step_item(1'b0, 8'h00));
        send_item(step_item(1'b0, 8'h80));

        // Zero sizes act as one
        write_reg(REG_NUM_COLUMNS, 7'd0);
        write_reg(REG_NUM_ROWS, 7'd0);
        send_item(step_item(1'b1, 8'h00));
        send_item(step_item(1'b0, 8'h01));

        // Oversized and maximum sides
        write_reg(REG_NUM_COLUMNS, 7'd127);
        write_reg(REG_NUM_ROWS, 7'd64);
        send_item(step_item(1'b1, 8'h00));
        send_item(step_item(1'b0, 8'hFE));
        send_item(step_item(1'b0, 8'h7F));
        send_item(step_item(1'b0, 8'h03));

        // Two cells: carve, pop to empty stack, then step after done
        write_reg(REG_NUM_COLUMNS, 7'd2);
        write_reg(REG_NUM_ROWS, 7'd1);
        send_item(step_item(1'b1, 8'h33));
        send_item(step_item(1'b0, 8'hCC));
        send_item(step_item(1'b0, 8'h0F));
        send_item(step_item(1'b0, 8'hF0));

        // Random walks: resize, restart, walk to completion with a little noise
        cols_now   = 7'd2;
        rows_now   = 7'd1;
        steps_sent = 0;
        while (steps_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                7:
                begin
                    cols_now = pick_size();
                    write_reg(REG_NUM_COLUMNS, cols_now);
                end
                8:
                begin
                    rows_now = pick_size();
                    write_reg(REG_NUM_ROWS, rows_now);
                end
                9:
                begin
                    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                              CFG_DATA_W'($urandom_range(0, 127)));
                    cols_now = pick_size();
                    write_reg(REG_NUM_COLUMNS, cols_now);
                end
                default:
                begin
                    cols_now = pick_size();
                    rows_now = pick_size();
                    write_reg(REG_NUM_COLUMNS, cols_now);
                    write_reg(REG_NUM_ROWS, rows_now);
                end
            endcase
            send_item(step_item(1'b1, RAND_W'($urandom_range(0, 255))));
            steps_sent++;

            // A full maze takes two steps per cell beyond the first
            cells    = sb.clamp_dim(cols_now) * sb.clamp_dim(rows_now);
            walk_len = (cells > 40) ? $urandom_range(10, 100)
                                    : 2 * cells + $urandom_range(0, 3);
            for (int s = 0; s < walk_len; s++)
            begin
                noise = $urandom_range(0, 99);
                if (noise == 0)
                begin
                    send_item(step_item(1'b1, RAND_W'($urandom_range(0, 255))));
                end
                else
                begin
                    // Resize one side in the middle of a walk
                    if (noise < 3)
                    begin
                        if ($urandom_range(0, 1))
                        begin
                            cols_now = pick_size();
                            write_reg(REG_NUM_COLUMNS, cols_now);
                        end
                        else
                        begin
                            rows_now = pick_size();
                            write_reg(REG_NUM_ROWS, rows_now);
                        end
                    end
                    send_item(step_item(1'b0, RAND_W'($urandom_range(0, 255))));
                end
                steps_sent++;
            end
        end

        // Drain outstanding moves, then watch for stray results
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/mcb_pkg.sv
sv/mcb_ctrl.sv
sv/mcb_dpath.sv
sv/maze_carve_backtracker_top.sv
sim/tb_maze_carve_backtracker_top.sv
